FILE: hw/rtl/plst_pkg.sv
// Shared types and constants for the positional list shift table.
// Used by plst_cell and positional_list_shift_table_core; no dependencies.
package plst_pkg;

  localparam int CAPACITY_DEF  = 16;
  localparam int WORD_BITS_DEF = 32;

  // Fixed port field widths
  localparam int ACTION_W  = 3;
  localparam int POS_W     = 5;
  localparam int IN_WORD_W = 32;
  localparam int STATUS_W  = 2;
  localparam int COUNT_W   = 5;

  typedef enum logic [ACTION_W-1:0] {
    A_APPEND = 3'd0,
    A_INSERT = 3'd1,
    A_REMOVE = 3'd2,
    A_ERASE  = 3'd3,
    A_READ   = 3'd4
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_RANGE   = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

  // Broadcast from the controller to every slot cell
  typedef struct packed {
    logic    apply;
    action_t act;
  } cell_ctl_t;

endpackage

FILE: hw/rtl/plst_cell.sv
// One slot cell of the list chain: holds a word, shifts to/from neighbors,
// and carries the erase-match and read chains one cell per cycle. Uses plst_pkg.
module plst_cell #(
  parameter int INDEX     = 0,
  parameter int WORD_BITS = plst_pkg::WORD_BITS_DEF,
  parameter int CW        = plst_pkg::POS_W
) (
  input  logic                  clk,
  input  logic                  rst,
  input  plst_pkg::cell_ctl_t   ctl,
  input  logic [CW-1:0]         pos,
  input  logic [CW-1:0]         fill,
  input  logic [WORD_BITS-1:0]  word,
  input  logic [WORD_BITS-1:0]  left_slot,
  input  logic [WORD_BITS-1:0]  right_slot,
  input  logic                  seen_in,
  input  logic [WORD_BITS-1:0]  rd_in,
  output logic [WORD_BITS-1:0]  slot,
  output logic                  seen,
  output logic [WORD_BITS-1:0]  rd
);
  import plst_pkg::*;

  localparam logic [CW-1:0] MY_IDX = CW'(INDEX);

  logic                 live;
  logic                 at_pos;
  logic                 above_pos;
  logic                 match;
  logic [WORD_BITS-1:0] slot_next;

  always_comb begin
    live      = (MY_IDX < fill);
    at_pos    = (MY_IDX == pos);
    above_pos = (MY_IDX > pos);
    match     = live && (slot == word);
    slot_next = slot;
    if (ctl.apply) begin
      unique case (ctl.act)
        A_APPEND: begin
          if (MY_IDX == fill) slot_next = word;
        end
        A_INSERT: begin
          if (at_pos) slot_next = word;
          else if (above_pos) slot_next = left_slot;
        end
        A_REMOVE: begin
          if (at_pos || above_pos) slot_next = right_slot;
        end
        // first match at or below this cell: close the gap
        A_ERASE: begin
          if (seen_in || match) slot_next = right_slot;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= '0;
    end else begin
      slot <= slot_next;
    end
  end

  // seen: some live cell at or below this one matches; rd: read data heading down
  always_ff @(posedge clk) begin
    seen <= seen_in || match;
    rd   <= (live && at_pos) ? slot : rd_in;
  end

endmodule

FILE: hw/rtl/positional_list_shift_table_core.sv
// Top level of the positional list shift table: controller, result register
// and the chain of plst_cell slot cells. Uses plst_pkg.
//
// Usage:
//   Input channel (in_valid/in_stall) carries action, slot_index, word_in.
//   Output channel (out_valid/out_stall) carries status, word_out, count;
//   exactly one result beat per input beat, in order.
//   Append, insert, remove and unused actions go from idle straight to the
//   finish step, which registers the result once the output register is free;
//   the next beat can be taken when the block is back in idle.
//   Erase and read pass through the sweep state before the finish step.
//   The match and read chains move one cell per cycle and must cross all
//   CAPACITY cells before the result is known.
//   The block works on one item at a time; in_stall is high while it is busy.
//   A waiting result does not block the next beat from being taken; the
//   following result is held back until the output register drains.
//   Under out_stall the result register holds its beat unchanged.
//   Reset clears every slot and the fill level, not the count output; in_stall is high during reset and
//   the block is ready the cycle after.
module positional_list_shift_table_core #(
  parameter int CAPACITY  = plst_pkg::CAPACITY_DEF,
  parameter int WORD_BITS = plst_pkg::WORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [plst_pkg::ACTION_W-1:0]  action,
  input  logic [plst_pkg::POS_W-1:0]     slot_index,
  input  logic [plst_pkg::IN_WORD_W-1:0] word_in,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [plst_pkg::STATUS_W-1:0]  status,
  output logic [plst_pkg::IN_WORD_W-1:0] word_out,
  output logic [plst_pkg::COUNT_W-1:0]   count
);
  import plst_pkg::*;

  localparam int FW    = $clog2(CAPACITY + 1);
  localparam int CW    = (FW > POS_W) ? FW : POS_W;
  localparam int CNT_W = $clog2(CAPACITY);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SWEEP  = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t                 state;
  state_t                 state_next;
  logic [CNT_W-1:0]       cnt;
  logic [FW-1:0]          fill;
  logic [FW-1:0]          fill_next;

  action_t                act_q;
  logic [POS_W-1:0]       pos_q;
  logic [WORD_BITS-1:0]   word_q;

  status_t                status_q;
  logic [IN_WORD_W-1:0]   word_out_q;
  logic [COUNT_W-1:0]     count_q;

  logic                   in_take;
  logic                   out_free;
  logic                   finish_go;
  logic                   legal;
  status_t                st;
  logic [IN_WORD_W-1:0]   rd_word;
  logic [63:0]            word_ext;
  logic [63:0]            rd_ext;
  logic [CW-1:0]          pos_ext;
  logic [CW-1:0]          fill_ext;
  logic [CW-1:0]          fill_after;
  logic                   full;
  cell_ctl_t              ctl;

  logic [WORD_BITS-1:0]   slot_a [CAPACITY];
  logic [WORD_BITS-1:0]   rd_a   [CAPACITY];
  logic                   seen_a [CAPACITY];

  assign in_stall  = rst || (state != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign finish_go = (state == S_FINISH) && out_free;

  assign word_ext = {32'b0, word_in};
  assign rd_ext   = 64'(rd_a[0]);
  assign pos_ext  = CW'(pos_q);
  assign fill_ext = CW'(fill);
  assign full     = (fill == FW'(CAPACITY));

  always_comb begin
    legal     = 1'b0;
    st        = ST_OK;
    fill_next = fill;
    rd_word   = '0;
    unique case (act_q)
      A_APPEND: begin
        if (full) st = ST_FULL;
        else begin
          legal     = 1'b1;
          fill_next = fill + FW'(1);
        end
      end
      A_INSERT: begin
        // position is checked before fullness
        if (pos_ext > fill_ext) st = ST_RANGE;
        else if (full) st = ST_FULL;
        else begin
          legal     = 1'b1;
          fill_next = fill + FW'(1);
        end
      end
      A_REMOVE: begin
        if (pos_ext >= fill_ext) st = ST_RANGE;
        else begin
          legal     = 1'b1;
          fill_next = fill - FW'(1);
        end
      end
      A_ERASE: begin
        if (seen_a[CAPACITY-1]) begin
          legal     = 1'b1;
          fill_next = fill - FW'(1);
        end else begin
          st = ST_MISSING;
        end
      end
      A_READ: begin
        if (pos_ext >= fill_ext) st = ST_RANGE;
        else rd_word = rd_ext[IN_WORD_W-1:0];
      end
      default: ;
    endcase
    fill_after = CW'(fill_next);
  end

  assign ctl.apply = finish_go && legal;
  assign ctl.act   = act_q;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_take) begin
          if ((action_t'(action) == A_ERASE) || (action_t'(action) == A_READ))
            state_next = S_SWEEP;
          else
            state_next = S_FINISH;
        end
      end
      S_SWEEP: begin
        if (cnt == CNT_W'(CAPACITY - 1)) state_next = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      out_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      state <= state_next;
      if (in_take) cnt <= '0;
      else if (state == S_SWEEP) cnt <= cnt + CNT_W'(1);
      if (finish_go) begin
        fill      <= fill_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      act_q  <= action_t'(action);
      pos_q  <= slot_index;
      word_q <= word_ext[WORD_BITS-1:0];
    end
    if (finish_go) begin
      status_q   <= st;
      word_out_q <= rd_word;
      count_q    <= fill_after[COUNT_W-1:0];
    end
  end

  assign status   = status_q;
  assign word_out = word_out_q;
  assign count    = count_q;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [WORD_BITS-1:0] left_w;
    logic [WORD_BITS-1:0] right_w;
    logic [WORD_BITS-1:0] rd_w;
    logic                 seen_w;

    if (g == 0) begin : g_first
      assign left_w = '0;
      assign seen_w = 1'b0;
    end else begin : g_mid_lo
      assign left_w = slot_a[g-1];
      assign seen_w = seen_a[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign right_w = '0;
      assign rd_w    = '0;
    end else begin : g_mid_hi
      assign right_w = slot_a[g+1];
      assign rd_w    = rd_a[g+1];
    end

    plst_cell #(
      .INDEX     (g),
      .WORD_BITS (WORD_BITS),
      .CW        (CW)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .pos        (pos_ext),
      .fill       (fill_ext),
      .word       (word_q),
      .left_slot  (left_w),
      .right_slot (right_w),
      .seen_in    (seen_w),
      .rd_in      (rd_w),
      .slot       (slot_a[g]),
      .seen       (seen_a[g]),
      .rd         (rd_a[g])
    );
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FW'(CAPACITY))
    else $error("fill beyond capacity");

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    !out_valid ##1 out_valid |-> $past(state == S_FINISH))
    else $error("result beat not produced by finish step");

  a_fill_change_at_finish: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && !$stable(fill) |-> $past(state == S_FINISH))
    else $error("fill changed outside finish step");

  a_no_take_while_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_SWEEP) |=> !in_take || (state == S_IDLE))
    else $error("input taken during sweep");

endmodule

FILE: bench/positional_list_shift_table_core_test.sv
// Self-checking bench for positional_list_shift_table_core: random list traffic
// with random gaps on both channels, and a scoreboard that models the list.
// Depends on plst_pkg and the core RTL only.
module positional_list_shift_table_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import plst_pkg::*;

  localparam int CAPACITY     = plst_pkg::CAPACITY_DEF;
  localparam int RANDOM_ITEMS = 1520;
  localparam int LONG_HOLD    = 70;
  localparam int SETTLE       = 3 * (CAPACITY + 2);
  localparam int TIMEOUT_NS   = 1_000_000;
  localparam int REPORT_LINES = 40;

  // action codes 5..7 are unused by the block
  localparam logic [ACTION_W-1:0] ACT_SPARE_LO = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_SPARE_HI = 3'd7;

  typedef struct packed {
    status_t              st;
    logic [IN_WORD_W-1:0] word;
    logic [COUNT_W-1:0]   cnt;
  } list_result_t;

  class list_scoreboard;
    logic [IN_WORD_W-1:0] slot_word [CAPACITY];
    int                   held;
    list_result_t         due_q [$];
    int                   mismatches;

    function new();
      foreach (slot_word[i]) slot_word[i] = '0;
      held       = 0;
      mismatches = 0;
    endfunction

    task report(input string what);
      mismatches++;
      // keep the log short when everything goes wrong
      if (mismatches <= REPORT_LINES)
        $display("[%0t] MISMATCH: %s", $realtime, what);
    endtask

    // close the gap at pos and clear the freed tail slot
    function void drop_slot(input int pos);
      for (int i = pos; i + 1 < held; i++)
        slot_word[i] = slot_word[i + 1];
      held--;
      slot_word[held] = '0;
    endfunction

    function void note_input(input logic [ACTION_W-1:0] act, input logic [POS_W-1:0] pos,
                             input logic [IN_WORD_W-1:0] w);
      list_result_t r;
      int           hit;
      r.st   = ST_OK;
      r.word = '0;
      hit    = -1;
      case (act)
        A_APPEND: begin
          if (held >= CAPACITY) r.st = ST_FULL;
          else begin
            slot_word[held] = w;
            held++;
          end
        end
        A_INSERT: begin
          // position is checked before fullness
          if (int'(pos) > held) r.st = ST_RANGE;
          else if (held >= CAPACITY) r.st = ST_FULL;
          else begin
            for (int i = held; i > int'(pos); i--)
              slot_word[i] = slot_word[i - 1];
            slot_word[pos] = w;
            held++;
          end
        end
        A_REMOVE: begin
          if (int'(pos) >= held) r.st = ST_RANGE;
          else drop_slot(int'(pos));
        end
        A_ERASE: begin
          for (int i = 0; i < held; i++)
            if (hit < 0 && slot_word[i] == w) hit = i;
          if (hit < 0) r.st = ST_MISSING;
          else drop_slot(hit);
        end
        A_READ: begin
          if (int'(pos) >= held) r.st = ST_RANGE;
          else r.word = slot_word[pos];
        end
        default: ;
      endcase
      r.cnt = COUNT_W'(held);
      due_q.push_back(r);
    endfunction

    task check_result(input logic [STATUS_W-1:0] st, input logic [IN_WORD_W-1:0] w,
                      input logic [COUNT_W-1:0] cnt);
      list_result_t exp;
      if (due_q.size() == 0) begin
        report("result beat with nothing outstanding");
      end else begin
        exp = due_q.pop_front();
        if (st !== exp.st)
          report($sformatf("status %0d, want %0d", st, exp.st));
        if (w !== exp.word)
          report($sformatf("word_out %h, want %h", w, exp.word));
        if (cnt !== exp.cnt)
          report($sformatf("count %0d, want %0d", cnt, exp.cnt));
      end
    endtask
  endclass

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  logic [ACTION_W-1:0]   action;
  logic [POS_W-1:0]      slot_index;
  logic [IN_WORD_W-1:0]  word_in;
  logic                  out_valid;
  logic                  out_stall;
  logic [STATUS_W-1:0]   status;
  logic [IN_WORD_W-1:0]  word_out;
  logic [COUNT_W-1:0]    count;

  list_scoreboard        sb = new();
  bit                    quiet;
  bit                    hold_long;
  logic [IN_WORD_W-1:0]  word_pool [8];

  positional_list_shift_table_core uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .action     (action),
    .slot_index (slot_index),
    .word_in    (word_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .word_out   (word_out),
    .count      (count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("tb: failure");
    $finish;
  end

  function automatic int draw_gap();
    return quiet ? 0 : $urandom_range(0, 17);
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result(status, word_out, count);
  end

  // result side: random stall before each beat, plus one long hold on request
  initial begin
    int n;
    out_stall = 1'b0;
    @(negedge rst);
    forever begin
      @(negedge clk);
      if (hold_long) begin
        out_stall = 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        out_stall = 1'b0;
        hold_long = 1'b0;
      end else begin
        n = draw_gap();
        if (n > 0) begin
          out_stall = 1'b1;
          repeat (n) @(negedge clk);
          out_stall = 1'b0;
        end
      end
      do @(posedge clk); while (!out_valid);
    end
  end

  // called and returns at a falling edge; valid stays high when the next beat follows
  task automatic send_beat(input logic [ACTION_W-1:0] act, input logic [POS_W-1:0] pos,
                           input logic [IN_WORD_W-1:0] w);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   = 1'b1;
    action     = act;
    slot_index = pos;
    word_in    = w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(act, pos, w);
    @(negedge clk);
  endtask

  task automatic drain_wait();
    in_valid = 1'b0;
    while (sb.due_q.size() != 0) @(negedge clk);
  endtask

  task automatic random_beat(input bit grow);
    logic [ACTION_W-1:0]  act;
    logic [POS_W-1:0]     pos;
    logic [IN_WORD_W-1:0] w;
    int                   roll;
    roll = $urandom_range(0, 99);
    // grow phases push toward a full list, shrink phases toward empty
    if (roll < (grow ? 35 : 12)) act = A_APPEND;
    else if (roll < (grow ? 60 : 24)) act = A_INSERT;
    else if (roll < (grow ? 72 : 54)) act = A_REMOVE;
    else if (roll < (grow ? 82 : 78)) act = A_ERASE;
    else if (roll < 97) act = A_READ;
    else act = 3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));

    if ($urandom_range(0, 3) == 0) pos = 5'($urandom_range(0, CAPACITY));
    else pos = 5'($urandom_range(0, sb.held));

    if (act == A_ERASE && sb.held > 0 && $urandom_range(0, 1) == 0)
      w = sb.slot_word[$urandom_range(0, sb.held - 1)];
    else if ($urandom_range(0, 9) < 6)
      w = word_pool[$urandom_range(0, 7)];
    else
      w = $urandom();
    send_beat(act, pos, w);
  endtask

  initial begin
    int burst_left;
    rst        = 1'b1;
    in_valid   = 1'b0;
    action     = A_APPEND;
    slot_index = '0;
    word_in    = '0;
    quiet      = 1'b0;
    hold_long  = 1'b0;
    burst_left = 0;
    word_pool[0] = '0;
    word_pool[1] = '1;
    word_pool[2] = 32'h8000_0000;
    word_pool[3] = 32'h0000_0001;
    for (int i = 4; i < 8; i++) word_pool[i] = $urandom();

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // empty list corners
    send_beat(A_READ, 5'd0, '0);
    send_beat(A_REMOVE, 5'd0, '0);
    send_beat(A_ERASE, 5'd0, '0);
    send_beat(A_INSERT, 5'd1, 32'hDEAD_BEEF);
    send_beat(A_INSERT, 5'd0, '1);
    // fill to capacity; slot_index is don't-care for append
    for (int i = 1; i < CAPACITY; i++)
      send_beat(A_APPEND, 5'($urandom_range(0, CAPACITY)),
                (i == 1) ? 32'h0 : (i == 2) ? 32'h8000_0000 : $urandom());
    send_beat(A_APPEND, 5'd0, 32'h1);
    send_beat(A_INSERT, 5'(CAPACITY), 32'h1);
    send_beat(A_INSERT, 5'd3, 32'h1);
    send_beat(A_READ, 5'(CAPACITY - 1), '0);
    send_beat(A_READ, 5'(CAPACITY), '0);
    send_beat(A_ERASE, 5'd7, 32'h0);
    send_beat(A_REMOVE, 5'(CAPACITY - 2), '0);
    send_beat(ACT_SPARE_LO, 5'(CAPACITY), '1);
    send_beat(ACT_SPARE_HI, 5'd0, '1);
    send_beat(A_INSERT, 5'(CAPACITY - 2), 32'h5A5A_A5A5);

    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k % 300 == 150) begin
        // stall results for a long stretch while beats keep coming
        hold_long  = 1'b1;
        burst_left = 24;
      end
      if (k % 300 == 299) drain_wait();
      quiet = (burst_left > 0) || ((k / 100) % 4 == 3);
      if (burst_left > 0) burst_left--;
      random_beat((k / 40) % 2 == 0);
    end
    in_valid = 1'b0;

    while (sb.due_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (sb.mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
